FILE: rtl/lppd_pkg.sv
package lppd_pkg;

  localparam int unsigned HDR_LEN    = 4;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned HCNT_W     = 3;
  localparam int unsigned OUT_DATA_W = ID_W + BYTE_W;

  // header byte positions (count of header bytes already taken)
  localparam logic [1:0] HDR_ID_LO  = 2'd0;
  localparam logic [1:0] HDR_ID_HI  = 2'd1;
  localparam logic [1:0] HDR_LEN_LO = 2'd2;
  localparam logic [1:0] HDR_LEN_HI = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   frame_id;
    logic [BYTE_W-1:0] payload_byte;
    logic              has_byte;
    logic              frame_end;
  } lppd_res_t;

endpackage

FILE: rtl/lppd_step.sv
module lppd_step
  import lppd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,      // byte consumed this cycle
  input  logic [BYTE_W-1:0] byte_in,
  output logic              res_vld,   // consuming this byte yields a result
  output lppd_res_t         res
);

  logic [HCNT_W-1:0] hcnt_r, hcnt_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [7:0]        len_lo_r, len_lo_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;

  logic              in_payload;
  logic [HCNT_W-1:0] hcnt_eff;
  logic [LEN_W-1:0]  new_len;

  always_comb begin
    hcnt_nxt   = hcnt_r;
    id_nxt     = id_r;
    len_lo_nxt = len_lo_r;
    left_nxt   = left_r;
    res_vld    = 1'b0;
    res        = '0;
    res.frame_id = id_r;
    new_len    = {byte_in, len_lo_r};

    in_payload = (hcnt_r >= HCNT_W'(HDR_LEN)) && (left_r != '0);
    // stale payload state with nothing left restarts a header
    hcnt_eff   = (hcnt_r >= HCNT_W'(HDR_LEN)) ? '0 : hcnt_r;

    if (in_payload) begin
      left_nxt         = left_r - LEN_W'(1);
      res_vld          = 1'b1;
      res.payload_byte = byte_in;
      res.has_byte     = 1'b1;
      if (left_r == LEN_W'(1)) begin
        hcnt_nxt      = '0;
        res.frame_end = 1'b1;
      end
    end else begin
      hcnt_nxt = hcnt_eff + HCNT_W'(1);
      case (hcnt_eff[1:0])
        HDR_ID_LO:  id_nxt     = {id_r[ID_W-1:8], byte_in};
        HDR_ID_HI:  id_nxt     = {byte_in, id_r[7:0]};
        HDR_LEN_LO: len_lo_nxt = byte_in;
        HDR_LEN_HI: begin
          left_nxt = new_len;
          if (new_len == '0) begin
            hcnt_nxt      = '0;
            res_vld       = 1'b1;
            res.frame_end = 1'b1;
          end
        end
        default: hcnt_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r   <= '0;
      id_r     <= '0;
      len_lo_r <= '0;
      left_r   <= '0;
    end else if (fire) begin
      hcnt_r   <= hcnt_nxt;
      id_r     <= id_nxt;
      len_lo_r <= len_lo_nxt;
      left_r   <= left_nxt;
    end
  end

endmodule

FILE: rtl/lppd_out_stage.sv
module lppd_out_stage
  import lppd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  lppd_res_t res,
  output logic      space,     // a new result can be loaded this cycle
  output logic      vld,
  input  logic      rdy,
  output lppd_res_t res_q
);

  logic      vld_r;
  lppd_res_t res_r;

  assign space = !vld_r || rdy;
  assign vld   = vld_r;
  assign res_q = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (space) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && space) begin
      res_r <= res;
    end
  end

endmodule

FILE: rtl/length_prefixed_packet_deframer_core.sv
// Channel | Dir | Ports         | Contents
// in_     | in  | tvalid/tready | tdata[7:0] = in_byte
// out_    | out | tvalid/tready | tdata[15:0] = frame_id, tdata[23:16] = payload_byte,
//         |     |               | tuser = has_byte, tlast = frame_end
//
// One byte per cycle sustained while the result side does not stall: each byte
// is held in the input register, then the header/payload counter update and the
// result register load happen in the same cycle. A result word passes through the
// input register and then the result register before it is offered on out_.
// Header bytes produce no result and never wait on the result side, except the
// last header byte of an empty frame, which emits the marker word.
// Reset (rst_n low, synchronous) clears the counters, held id and both valids.
// A stalled result holds; a byte that yields a result leaves the input register
// only when the result register is free or being taken in that cycle.
module length_prefixed_packet_deframer_core
  import lppd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] in_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [15:0] frame_id, [23:16] payload_byte
  output logic                  out_tlast,  // frame_end
  output logic                  out_tuser   // has_byte
);

  // input register
  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;

  logic      step_fire;
  logic      res_vld;
  lppd_res_t res;
  logic      out_space;
  lppd_res_t res_q;

  // a byte leaves the input register unless its result has nowhere to go
  assign step_fire = in_vld_r && (!res_vld || out_space);
  assign in_tready = !in_vld_r || step_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  lppd_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (step_fire),
    .byte_in (in_byte_r),
    .res_vld (res_vld),
    .res     (res)
  );

  lppd_out_stage u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (step_fire && res_vld),
    .res   (res),
    .space (out_space),
    .vld   (out_tvalid),
    .rdy   (out_tready),
    .res_q (res_q)
  );

  assign out_tdata = {res_q.payload_byte, res_q.frame_id};
  assign out_tlast = res_q.frame_end;
  assign out_tuser = res_q.has_byte;

endmodule

FILE: rtl/lppd_checker.sv
module lppd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // stalled word holds its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // empty-frame marker: no byte, zero payload, ends the frame
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && (out_tdata[23:16] == 8'd0))
    else $error("bad empty-frame marker");

  // a result that is not the frame end always carries a byte
  a_mid_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser)
    else $error("mid-frame result without byte");

  // nothing valid right after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // input side is free right after reset
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> in_tready || !in_tvalid)
    else $error("input blocked after reset");

endmodule

bind length_prefixed_packet_deframer_core lppd_checker u_lppd_checker (.*);

FILE: bench/length_prefixed_packet_deframer_core_tb.sv
`timescale 1ns / 100ps

module length_prefixed_packet_deframer_core_tb;
  import lppd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned RANDOM_BYTES = 1500;
  localparam int unsigned DRAIN_CYCLES = 8;  // input and result registers plus margin

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_TOGGLE} rdy_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata = '0;      // [7:0] in_byte
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;          // [15:0] frame_id, [23:16] payload_byte
  logic                  out_tlast;          // frame_end
  logic                  out_tuser;          // has_byte

  // stream bytes waiting to go out, and results the deframer owes us
  logic [BYTE_W-1:0] stream_bytes[$];
  lppd_res_t         owed_words[$];

  // shadow deframer state
  logic [HCNT_W-1:0] hdr_taken = '0;
  logic [ID_W-1:0]   cur_id = '0;
  logic [LEN_W-1:0]  cur_len = '0;
  logic [LEN_W-1:0]  payload_left = '0;

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned pause_at = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned mode_left = 0;
  rdy_mode_t   rdy_mode = RDY_ALWAYS;

  length_prefixed_packet_deframer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // Advance the shadow deframer by one stream byte; queue any result it owes.
  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    lppd_res_t r;
    if (hdr_taken >= HDR_LEN && payload_left != 0) begin
      payload_left = payload_left - 1'b1;
      r = '{cur_id, b, 1'b1, payload_left == 0};
      owed_words.push_back(r);
      if (payload_left == 0) hdr_taken = '0;
    end else begin
      // payload done (or never started): this byte opens a new header
      if (hdr_taken >= HDR_LEN) hdr_taken = '0;
      case (hdr_taken[1:0])
        HDR_ID_LO:  cur_id[7:0]   = b;
        HDR_ID_HI:  cur_id[15:8]  = b;
        HDR_LEN_LO: cur_len[7:0]  = b;
        default:    cur_len[15:8] = b;
      endcase
      hdr_taken = hdr_taken + 1'b1;
      if (hdr_taken == HDR_LEN) begin
        payload_left = cur_len;
        // empty frame: one marker word, no byte, frame closed
        if (cur_len == 0) begin
          hdr_taken = '0;
          r = '{cur_id, '0, 1'b0, 1'b1};
          owed_words.push_back(r);
        end
      end
    end
  endtask

  task automatic queue_header(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len);
    stream_bytes.push_back(id[7:0]);
    stream_bytes.push_back(id[15:8]);
    stream_bytes.push_back(len[7:0]);
    stream_bytes.push_back(len[15:8]);
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Sender: bursts of back-to-back bytes separated by random gaps, with one pause until owed results drain.
  always @(posedge clk) begin : feed
    logic go;
    go = 1'b0;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      burst_left = $urandom_range(1, 12);
      gap_left   = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        deframe_byte(in_tdata);
        bytes_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (bytes_sent == pause_at && owed_words.size() != 0) begin
          go = 1'b0;  // hold off until the deframer has caught up
        end else if (gap_left != 0) begin
          gap_left--;
        end else if (stream_bytes.size() != 0) begin
          go = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        in_tvalid <= go;
        if (go) in_tdata <= stream_bytes.pop_front();
      end
    end
  end

  // Receiver: checks each taken word; the stall pattern switches mode when its mode counter runs out.
  always @(posedge clk) begin : sink
    lppd_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (owed_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h last %b user %b",
                   $time, out_tdata, out_tlast, out_tuser);
          mismatches++;
        end else begin
          want = owed_words.pop_front();
          check_field("frame_id", want.frame_id, out_tdata[15:0]);
          check_field("payload_byte", 16'(want.payload_byte), 16'(out_tdata[23:16]));
          check_field("has_byte", 16'(want.has_byte), 16'(out_tuser));
          check_field("frame_end", 16'(want.frame_end), 16'(out_tlast));
        end
      end
      if (mode_left == 0) begin
        rdy_mode  = rdy_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 128);
      end else begin
        mode_left--;
      end
      case (rdy_mode)
        RDY_ALWAYS: out_tready <= 1'b1;
        RDY_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RDY_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default:    out_tready <= ~out_tready;
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
    int unsigned      pick;

    // directed: empty frames at id extremes, a single-byte frame, payload extremes
    queue_header(16'h0000, 16'd0);
    queue_header(16'hFFFF, 16'd0);
    queue_header(16'h1234, 16'd1);
    stream_bytes.push_back(8'h00);
    queue_header(16'hFFFF, 16'd3);
    stream_bytes.push_back(8'hFF);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h80);

    // random frames; length mostly short, a few past one byte of length
    while (stream_bytes.size() < RANDOM_BYTES) begin
      if (pause_at == 0 && stream_bytes.size() > RANDOM_BYTES / 2)
        pause_at = stream_bytes.size();
      id   = ID_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 15)      len = '0;
      else if (pick < 80) len = LEN_W'($urandom_range(1, 8));
      else if (pick < 96) len = LEN_W'($urandom_range(9, 64));
      else                len = LEN_W'($urandom_range(250, 320));
      queue_header(id, len);
      repeat (len) stream_bytes.push_back(BYTE_W'($urandom));
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (stream_bytes.size() != 0 || in_tvalid) @(posedge clk);
    while (owed_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && owed_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
